@@ rtl/core/ecw_pkg.sv @@
// Package for the exponential cost weighting block: widths, constants and
// the shared controller/datapath command and status types. No dependencies.
package ecw_pkg;

    localparam int MaxRollouts = 32;
    localparam int IdxW = $clog2(MaxRollouts);
    localparam int CntW = $clog2(MaxRollouts + 1);

    localparam logic [7:0]  SENS_RESET = 8'd10;
    localparam logic [32:0] SPAN_ONE = 33'd65536;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    // Reciprocals for dividing by 3 (shift 33) and by 5 (shift 34).
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;
    localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MM_FIRST,
        OP_MM_NEXT,
        OP_SPAN,
        OP_DIFF,
        OP_ADIV_START,
        OP_DIV_STEP,
        OP_EXP_A,
        OP_EXP_B,
        OP_HORNER,
        OP_HOR_DIV,
        OP_EXP_E,
        OP_TERM,
        OP_PDIV_START,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t             op;
        logic [IdxW-1:0] idx;
        logic [2:0]      k;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_sum;
    } dp_sts_t;

endpackage

@@ rtl/core/ecw_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on ecw_pkg.
module ecw_div
    import ecw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [55:0] dividend,
    input  logic [39:0] divisor,
    output logic        done,
    output logic [55:0] quotient
);
    logic [55:0] quot_reg, quot_next;
    logic [40:0] rem_reg, rem_next;
    logic [39:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [40:0] trial;
    logic [41:0] diff;

    always_comb begin
        quot_next = quot_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[39:0], quot_reg[55]};
        diff = {1'b0, trial} - {2'b0, dsr_reg};
        if (start) begin
            quot_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
            cnt_next = 6'd56;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[41]) begin
                rem_next = diff[40:0];
                quot_next = {quot_reg[54:0], 1'b1};
            end else begin
                rem_next = trial;
                quot_next = {quot_reg[54:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = busy_reg && (cnt_reg == 6'd1);
    assign quotient = quot_reg;
endmodule

@@ rtl/core/ecw_datapath.sv @@
// Datapath: rollout stores, min/max, exponent argument, exp approximation,
// terms, sum and probability. Depends on ecw_pkg and ecw_div.
module ecw_datapath
    import ecw_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  dp_cmd_t       cmd,
    input  logic [7:0]    sensitivity,
    input  logic [31:0]   in_cost,
    input  logic [15:0]   in_weight,
    output logic          div_done,
    output dp_sts_t       sts,
    output logic [15:0]   probability
);
    logic [31:0] cost_mem [MaxRollouts];
    logic [15:0] weight_mem [MaxRollouts];
    logic [31:0] term_mem [MaxRollouts];

    logic signed [31:0] cost_min_reg, cost_max_reg;
    logic [32:0] span_reg, diff_reg;
    logic [39:0] sum_reg;
    logic [55:0] a_reg;
    logic [37:0] b_full_reg;
    logic [5:0]  n_reg;
    logic [29:0] y_reg;
    logic [30:0] t_reg;
    logic [30:0] yt_reg;
    logic [31:0] e_reg;
    logic [15:0] w_reg;
    logic [31:0] rd_cost;
    logic [15:0] rd_weight;
    logic [31:0] rd_term;
    logic        div_start;
    logic [55:0] div_dvd;
    logic [39:0] div_dsr;
    logic [55:0] div_q;
    logic [40:0] hd;
    logic [60:0] yt;
    logic [30:0] k_src;
    logic [31:0] k_recip;
    logic [62:0] k_prod;
    logic [30:0] yt_q;
    logic [45:0] y_full;
    logic [37:0] b_calc;
    logic [31:0] e_calc;
    logic [47:0] term_full;
    logic signed [31:0] c_s;

    // Registered reads of the stores at the commanded index.
    always_ff @(posedge aclk) begin
        rd_cost <= cost_mem[cmd.idx];
        rd_weight <= weight_mem[cmd.idx];
        rd_term <= term_mem[cmd.idx];
        if (cmd.op == OP_LOAD) begin
            cost_mem[cmd.idx] <= in_cost;
            weight_mem[cmd.idx] <= in_weight;
        end
        if (cmd.op == OP_TERM) term_mem[cmd.idx] <= term_full[46:15];
    end

    assign c_s = rd_cost;
    assign hd = 41'(diff_reg) * 41'(sensitivity);

    // Any argument of 2^21 or more drives the exponent past 31, so only the
    // low bits of the quotient reach the multiplier.
    assign b_calc = (a_reg[55:21] != '0) ? '1 : a_reg[20:0] * LOG2E_Q16;
    assign y_full = b_full_reg[31:16] * LN2_Q30;

    // Horner step: the product is registered first, then divided by k.
    assign yt = y_reg * t_reg;
    assign k_src = (cmd.k == 3'd6) ? {1'b0, yt_reg[30:1]} : yt_reg;
    assign k_recip = (cmd.k == 3'd5) ? RECIP5 : RECIP3;
    assign k_prod = k_src * k_recip;
    always_comb begin
        case (cmd.k)
            3'd1: yt_q = yt_reg;
            3'd2: yt_q = {1'b0, yt_reg[30:1]};
            3'd3: yt_q = {1'b0, k_prod[62:33]};
            3'd4: yt_q = {2'b0, yt_reg[30:2]};
            3'd5: yt_q = {2'b0, k_prod[62:34]};
            3'd6: yt_q = {1'b0, k_prod[62:33]};
            default: yt_q = yt_reg;
        endcase
    end

    assign e_calc = (n_reg > 6'd31) ? 32'd0 : ({t_reg, 1'b0} >> n_reg[4:0]);
    assign term_full = w_reg * e_reg;

    assign div_start = (cmd.op == OP_ADIV_START) || (cmd.op == OP_PDIV_START);
    always_comb begin
        if (cmd.op == OP_PDIV_START) begin
            div_dvd = {8'd0, rd_term, 16'd0};
            div_dsr = sum_reg;
        end else begin
            div_dvd = {hd[39:0], 16'd0};
            div_dsr = {7'd0, span_reg};
        end
    end

    ecw_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_dvd), .divisor(div_dsr),
        .done(div_done), .quotient(div_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cost_min_reg <= '0;
            cost_max_reg <= '0;
            sum_reg <= '0;
        end else begin
            unique case (cmd.op)
                OP_MM_FIRST: begin
                    cost_min_reg <= c_s;
                    cost_max_reg <= c_s;
                    sum_reg <= '0;
                end
                OP_MM_NEXT: begin
                    if (c_s < cost_min_reg) cost_min_reg <= c_s;
                    if (c_s > cost_max_reg) cost_max_reg <= c_s;
                end
                OP_TERM: sum_reg <= sum_reg + 40'(term_full[46:15]);
                default: ;
            endcase
        end
        unique case (cmd.op)
            OP_SPAN: span_reg <= (cost_max_reg == cost_min_reg) ? SPAN_ONE :
                33'($signed({cost_max_reg[31], cost_max_reg})
                    - $signed({cost_min_reg[31], cost_min_reg}));
            OP_DIFF: begin
                diff_reg <= 33'($signed({c_s[31], c_s})
                    - $signed({cost_min_reg[31], cost_min_reg}));
                w_reg <= rd_weight;
            end
            OP_DIV_STEP: a_reg <= div_q;
            OP_EXP_A: b_full_reg <= b_calc;
            OP_EXP_B: begin
                n_reg <= b_full_reg[37:32];
                y_reg <= y_full[45:16];
                t_reg <= ONE_Q30;
            end
            OP_HORNER: yt_reg <= yt[60:30];
            OP_HOR_DIV: t_reg <= ONE_Q30 - yt_q;
            OP_EXP_E: e_reg <= e_calc;
            OP_OUT: probability <= (sum_reg == '0) ? 16'd0 :
                ((div_q > 56'd65535) ? 16'hFFFF : div_q[15:0]);
            default: ;
        endcase
    end

    assign sts.zero_sum = (sum_reg == '0);
endmodule

@@ rtl/core/ecw_ctrl.sv @@
// Controller state machine: load, min/max pass, term pass, output pass.
// Depends on ecw_pkg.
module ecw_ctrl
    import ecw_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  logic          s_last_rollout,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [5:0]    m_rollout_index,
    output logic          m_last_result,
    output logic          m_zero_sum,
    input  logic          div_done,
    input  dp_sts_t       sts,
    output dp_cmd_t       cmd
);
    localparam logic [4:0] S_LOAD = 5'd0, S_MM_RD = 5'd1, S_MM = 5'd2,
        S_SPAN = 5'd3, S_T_RD = 5'd4, S_DIFF = 5'd5, S_ADIV = 5'd6,
        S_DIV = 5'd7, S_EA = 5'd8, S_EB = 5'd9, S_EC = 5'd10,
        S_HMUL = 5'd11, S_HDIV = 5'd12, S_EE = 5'd13, S_TERM = 5'd14,
        S_P_RD = 5'd15, S_PDIV = 5'd16, S_PWAIT = 5'd17, S_OUT = 5'd18,
        S_OUT2 = 5'd19;

    logic [4:0]      state_reg, state_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [IdxW-1:0] idx_reg, idx_next;
    logic [2:0]      k_reg, k_next;
    logic            acc;
    logic [IdxW-1:0] last_idx;

    assign acc = s_valid && s_ready;
    assign s_ready = (state_reg == S_LOAD);
    assign last_idx = IdxW'(cnt_reg - CntW'(1));

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        k_next = k_reg;
        cmd.op = OP_NONE;
        cmd.idx = idx_reg;
        cmd.k = k_reg;
        m_valid = 1'b0;
        unique case (state_reg)
            S_LOAD: begin
                cmd.idx = IdxW'(cnt_reg);
                if (acc) begin
                    if (cnt_reg < CntW'(MaxRollouts)) begin
                        cmd.op = OP_LOAD;
                        cnt_next = cnt_reg + CntW'(1);
                    end
                    if (s_last_rollout && cnt_next != '0) begin
                        state_next = S_MM_RD;
                        idx_next = '0;
                    end
                end
            end
            S_MM_RD: state_next = S_MM;
            S_MM: begin
                cmd.op = (idx_reg == '0) ? OP_MM_FIRST : OP_MM_NEXT;
                if (idx_reg == last_idx) begin
                    state_next = S_SPAN;
                end else begin
                    idx_next = idx_reg + IdxW'(1);
                    state_next = S_MM_RD;
                end
            end
            S_SPAN: begin
                cmd.op = OP_SPAN;
                idx_next = '0;
                state_next = S_T_RD;
            end
            S_T_RD: state_next = S_DIFF;
            S_DIFF: begin
                cmd.op = OP_DIFF;
                state_next = S_ADIV;
            end
            S_ADIV: begin
                cmd.op = OP_ADIV_START;
                state_next = S_DIV;
            end
            S_DIV: if (div_done) state_next = S_EA;
            S_EA: begin
                cmd.op = OP_DIV_STEP;
                state_next = S_EB;
            end
            S_EB: begin
                cmd.op = OP_EXP_A;
                state_next = S_EC;
            end
            S_EC: begin
                cmd.op = OP_EXP_B;
                k_next = 3'd6;
                state_next = S_HMUL;
            end
            S_HMUL: begin
                cmd.op = OP_HORNER;
                state_next = S_HDIV;
            end
            S_HDIV: begin
                cmd.op = OP_HOR_DIV;
                if (k_reg == 3'd1) begin
                    state_next = S_EE;
                end else begin
                    k_next = k_reg - 3'd1;
                    state_next = S_HMUL;
                end
            end
            S_EE: begin
                cmd.op = OP_EXP_E;
                state_next = S_TERM;
            end
            S_TERM: begin
                cmd.op = OP_TERM;
                if (idx_reg == last_idx) begin
                    idx_next = '0;
                    state_next = S_P_RD;
                end else begin
                    idx_next = idx_reg + IdxW'(1);
                    state_next = S_T_RD;
                end
            end
            S_P_RD: state_next = S_PDIV;
            S_PDIV: begin
                cmd.op = OP_PDIV_START;
                state_next = S_PWAIT;
            end
            S_PWAIT: if (div_done) state_next = S_OUT;
            S_OUT: begin
                cmd.op = OP_OUT;
                state_next = S_OUT2;
            end
            S_OUT2: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (idx_reg == last_idx) begin
                        cnt_next = '0;
                        state_next = S_LOAD;
                    end else begin
                        idx_next = idx_reg + IdxW'(1);
                        state_next = S_P_RD;
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD;
            cnt_reg <= '0;
            idx_reg <= '0;
            k_reg <= '0;
        end else begin
            state_reg <= state_next;
            k_reg <= k_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
        end
    end

    assign m_rollout_index = 6'(idx_reg);
    assign m_last_result = (idx_reg == last_idx);
    assign m_zero_sum = sts.zero_sum;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("output while loading");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_rollout_index))
        else $error("result lost under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CntW'(MaxRollouts)) else $error("count overflow");
endmodule

@@ rtl/core/exponential_cost_weighting.sv @@
// Exponential cost weighting of rollout sets: top level joining the
// controller and the datapath. Depends on ecw_pkg, ecw_ctrl, ecw_datapath.
//
// Usage: rollouts are loaded as requests on the s_ channel, one per cycle,
// each a Q16.16 cost and a Q2.14 weight; s_last_rollout closes the set.
// Up to 32 rollouts are stored; further ones are dropped, but a closing
// request still closes the set. The block then computes min and max
// (a read and a compare per rollout, then the span), each term (per
// rollout: a 56-step serial divide, the exp multiplies, six Horner steps
// of a multiply and a divide by k, and the setup around them) and each
// probability (a serial divide of the term by the sum), delivering
// results on the m_ channel in load order.
// No new rollout is taken until the last result of a set is delivered.
// A stalled receiver holds the current result unchanged and delays the
// next probability by the length of the stall.
// sensitivity may be written when idle; reset sets it to 10 and
// empties the set.
module exponential_cost_weighting
    import ecw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_cost,
    input  logic [15:0] s_weight,
    input  logic        s_last_rollout,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_probability,
    output logic [5:0]  m_rollout_index,
    output logic        m_zero_sum,
    output logic        m_last_result
);
    logic [7:0] sens_reg;
    dp_cmd_t    cmd;
    dp_sts_t    sts;
    logic       div_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) sens_reg <= SENS_RESET;
        else if (cfg_we) sens_reg <= cfg_wdata;
    end

    ecw_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_last_rollout(s_last_rollout), .m_valid(m_valid), .m_ready(m_ready),
        .m_rollout_index(m_rollout_index), .m_last_result(m_last_result),
        .m_zero_sum(m_zero_sum), .div_done(div_done), .sts(sts), .cmd(cmd)
    );

    ecw_datapath u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sensitivity(sens_reg),
        .in_cost(s_cost), .in_weight(s_weight), .div_done(div_done),
        .sts(sts), .probability(m_probability)
    );
endmodule
